FILE: rtl/box_downsample_3x3_rgb_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 RGB box downsampler
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_3X3_RGB_MACROS_SVH
`define BOX_DOWNSAMPLE_3X3_RGB_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BD3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BD3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bd3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd3_pkg
// Shared widths, register indexes and arithmetic helpers of the downsampler.
// ----------------------------------------------------------------------------
package bd3_pkg;

    localparam int COLOR_W     = 8;
    localparam int RUN_W       = 10;
    localparam int SUM_W       = 12;
    localparam int XPOS_W      = 12;
    localparam int OUTX_W      = 11;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;

    localparam int MAX_OUT_WIDTH = 1024;
    localparam int ADDR_W        = $clog2(MAX_OUT_WIDTH);
    localparam int WORD_W        = 3 * SUM_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ENABLE = 1'd1;

    localparam logic [XPOS_W-1:0] IN_WIDTH_RESET = 12'd3072;

    // Row and column phases within a 3x3 block.
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    localparam logic [COLOR_W-1:0] WHITE_LEVEL = 8'd255;
    localparam logic [COLOR_W-1:0] GRID_GRAY   = 8'd128;

    // Exact floor(v / 3) for any 12-bit v: 5462 = ceil(2^14 / 3).
    localparam logic [12:0] RECIP3  = 13'd5462;
    // Exact floor(s / 9) for any 12-bit s: 3641 = ceil(2^15 / 9).
    localparam logic [11:0] RECIP9  = 12'd3641;

    // Output line width from the input line width, clipped to the column store.
    function automatic logic [OUTX_W-1:0] out_width(input logic [XPOS_W-1:0] w);
        logic [24:0] prod;
        logic [OUTX_W-1:0] q;
        prod = {13'd0, w} * {12'd0, RECIP3};
        q    = prod[24:14];
        if (q > OUTX_W'(MAX_OUT_WIDTH))
            q = OUTX_W'(MAX_OUT_WIDTH);
        return q;
    endfunction

    // Block average, truncated to 8 bits.
    function automatic logic [COLOR_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [23:0] prod;
        prod = {12'd0, s} * {12'd0, RECIP9};
        return prod[22:15];
    endfunction

    // Item held in the stage register, between the pixel input and the result register.
    typedef struct packed {
        logic                  wr;
        logic                  emit;
        logic                  first_row;
        logic [ADDR_W-1:0]     addr;
        logic [RUN_W-1:0]      run_red;
        logic [RUN_W-1:0]      run_green;
        logic [RUN_W-1:0]      run_blue;
        logic [COLOR_W-1:0]    overlay_red;
        logic [COLOR_W-1:0]    overlay_green;
        logic [COLOR_W-1:0]    overlay_blue;
        logic                  row_end;
    } stage_t;

endpackage

FILE: rtl/bd3_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bd3 channel interfaces
// Valid/ready channels for supersampled input pixels and output pixels.
// ----------------------------------------------------------------------------
interface bd3_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bd3_pkg::COLOR_W-1:0] pix_red;
    logic [bd3_pkg::COLOR_W-1:0] pix_green;
    logic [bd3_pkg::COLOR_W-1:0] pix_blue;
    logic [bd3_pkg::COLOR_W-1:0] overlay_red;
    logic [bd3_pkg::COLOR_W-1:0] overlay_green;
    logic [bd3_pkg::COLOR_W-1:0] overlay_blue;
    logic                        frame_start;

    modport source (
        output valid, pix_red, pix_green, pix_blue,
        output overlay_red, overlay_green, overlay_blue, frame_start,
        input  ready
    );
    modport sink (
        input  valid, pix_red, pix_green, pix_blue,
        input  overlay_red, overlay_green, overlay_blue, frame_start,
        output ready
    );
endinterface

interface bd3_res_if;
    logic                        valid;
    logic                        ready;
    logic [bd3_pkg::COLOR_W-1:0] out_red;
    logic [bd3_pkg::COLOR_W-1:0] out_green;
    logic [bd3_pkg::COLOR_W-1:0] out_blue;
    logic                        row_end;

    modport source (
        output valid, out_red, out_green, out_blue, row_end,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, row_end,
        output ready
    );
endinterface

FILE: rtl/box_downsample_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_3x3_rgb
// 3x3 box-filter decimation of a 24-bit RGB pixel stream with grid overlay.
// ----------------------------------------------------------------------------
// Usage: pixels of an image at three times the target resolution enter on
// the pixels channel in raster order, one transfer per pixel, with
// frame_start set on the first pixel of each frame. Every pixel that
// completes a 3x3 block produces one transfer on the results channel
// carrying the truncated block average per color and row_end on the last
// output pixel of a row; all other pixels produce no transfer.
// The block takes one pixel per clock while it is not stalled. The pixel
// transfer that completes a block loads the stage register while the column
// store is read, and the result register is loaded from the stage register
// when that advances; results.valid comes from the result register. The
// stage register is needed because the column store's read port is
// registered and is addressed at the input transfer.
// When the receiver stalls, the result register holds its transfer, the
// stage register keeps passing pixels that complete no block, and
// pixels.ready drops once a block-completing pixel reaches the stage
// register, until the result is taken. Configuration (in_width,
// grid_enable) is written on cfg_we.
// Reset clears the position counters and the running sums and loads the
// register defaults; the column store is not cleared, since the first row
// of each block row never reads it.
// ----------------------------------------------------------------------------
module box_downsample_3x3_rgb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bd3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bd3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    bd3_pix_if.sink                          pixels,
    bd3_res_if.source                        results
);

`include "box_downsample_3x3_rgb_macros.svh"

    // Configuration registers. The output line width is derived once, when
    // in_width is written, so the pixel path only compares against it.
    logic [bd3_pkg::XPOS_W-1:0]  in_width_reg;
    logic [bd3_pkg::OUTX_W-1:0]  out_width_reg;
    logic                        grid_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg    <= bd3_pkg::IN_WIDTH_RESET;
            out_width_reg   <= bd3_pkg::out_width(bd3_pkg::IN_WIDTH_RESET);
            grid_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bd3_pkg::REG_IN_WIDTH:
                begin
                    in_width_reg  <= cfg_wdata;
                    out_width_reg <= bd3_pkg::out_width(cfg_wdata);
                end
                bd3_pkg::REG_GRID_ENABLE:
                begin
                    grid_enable_reg <= cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Position state. The input column is tracked both as a plain count and
    // as a (block column, phase in block) pair, which avoids dividing by 3.
    logic [bd3_pkg::XPOS_W-1:0]  x_position_reg, x_position_next;
    logic [1:0]                  col_phase_reg, col_phase_next;
    logic [bd3_pkg::OUTX_W-1:0]  out_x_reg, out_x_next;
    logic [1:0]                  row_phase_reg, row_phase_next;
    logic [bd3_pkg::RUN_W-1:0]   run_red_reg, run_green_reg, run_blue_reg;
    logic [bd3_pkg::RUN_W-1:0]   run_red_next, run_green_next, run_blue_next;

    // Pipeline control.
    logic                        stage_valid_reg;
    bd3_pkg::stage_t             stage_reg, stage_next;
    logic                        stage_go;
    logic                        in_fire;
    logic                        out_valid_reg;

    // Output register payload.
    logic [bd3_pkg::COLOR_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic                        row_end_reg;

    // Column store with a registered read port.
    logic [bd3_pkg::WORD_W-1:0]  col_mem [bd3_pkg::MAX_OUT_WIDTH];
    logic [bd3_pkg::WORD_W-1:0]  rd_data_reg;

    // Current position, after a frame start mark has cleared it.
    logic [bd3_pkg::XPOS_W-1:0]  x_cur;
    logic [1:0]                  col_cur;
    logic [bd3_pkg::OUTX_W-1:0]  out_x_cur;
    logic [1:0]                  row_cur;
    logic                        run_clear;
    logic                        line_end;
    logic                        block_done;

    // The stage register advances whenever its item does not need the result
    // register or the result register is free or being emptied.
    assign stage_go = stage_valid_reg &&
                      (!stage_reg.emit || !out_valid_reg || results.ready);
    assign pixels.ready = !stage_valid_reg || stage_go;
    assign in_fire      = pixels.valid && pixels.ready;

    always_comb
    begin
        x_cur     = pixels.frame_start ? '0 : x_position_reg;
        col_cur   = pixels.frame_start ? bd3_pkg::PHASE_FIRST : col_phase_reg;
        out_x_cur = pixels.frame_start ? '0 : out_x_reg;
        row_cur   = pixels.frame_start ? bd3_pkg::PHASE_FIRST : row_phase_reg;

        // Running sums restart on the first pixel of every block column.
        run_clear      = pixels.frame_start || (col_cur == bd3_pkg::PHASE_FIRST);
        run_red_next   = (run_clear ? '0 : run_red_reg)   +
                         bd3_pkg::RUN_W'(pixels.pix_red);
        run_green_next = (run_clear ? '0 : run_green_reg) +
                         bd3_pkg::RUN_W'(pixels.pix_green);
        run_blue_next  = (run_clear ? '0 : run_blue_reg)  +
                         bd3_pkg::RUN_W'(pixels.pix_blue);

        // A block column closes on its third pixel if it lies inside the
        // output line; leftover columns are dropped.
        block_done = (col_cur == bd3_pkg::PHASE_LAST) && (out_x_cur < out_width_reg);
        line_end   = ({1'b0, x_cur} + 13'd1) >= {1'b0, in_width_reg};

        if (line_end)
        begin
            x_position_next = '0;
            col_phase_next  = bd3_pkg::PHASE_FIRST;
            out_x_next      = '0;
            row_phase_next  = (row_cur >= bd3_pkg::PHASE_LAST) ?
                              bd3_pkg::PHASE_FIRST : row_cur + 2'd1;
        end
        else
        begin
            x_position_next = x_cur + 12'd1;
            row_phase_next  = row_cur;
            if (col_cur == bd3_pkg::PHASE_LAST)
            begin
                col_phase_next = bd3_pkg::PHASE_FIRST;
                out_x_next     = out_x_cur + 11'd1;
            end
            else
            begin
                col_phase_next = col_cur + 2'd1;
                out_x_next     = out_x_cur;
            end
        end

        stage_next.wr            = block_done;
        stage_next.emit          = block_done && (row_cur == bd3_pkg::PHASE_LAST);
        stage_next.first_row     = (row_cur == bd3_pkg::PHASE_FIRST);
        stage_next.addr          = out_x_cur[bd3_pkg::ADDR_W-1:0];
        stage_next.run_red       = run_red_next;
        stage_next.run_green     = run_green_next;
        stage_next.run_blue      = run_blue_next;
        stage_next.overlay_red   = pixels.overlay_red;
        stage_next.overlay_green = pixels.overlay_green;
        stage_next.overlay_blue  = pixels.overlay_blue;
        stage_next.row_end       = ((out_x_cur + 11'd1) == out_width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_position_reg  <= '0;
            col_phase_reg   <= bd3_pkg::PHASE_FIRST;
            out_x_reg       <= '0;
            row_phase_reg   <= bd3_pkg::PHASE_FIRST;
            run_red_reg     <= '0;
            run_green_reg   <= '0;
            run_blue_reg    <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                x_position_reg <= x_position_next;
                col_phase_reg  <= col_phase_next;
                out_x_reg      <= out_x_next;
                row_phase_reg  <= row_phase_next;
                run_red_reg    <= run_red_next;
                run_green_reg  <= run_green_next;
                run_blue_reg   <= run_blue_next;
            end
            if (pixels.ready)
            begin
                stage_valid_reg <= pixels.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg <= stage_next;
        end
    end

    // Second stage: add the rows above from the column store, average, and
    // apply the grid substitution.
    logic [bd3_pkg::WORD_W-1:0]  prev_word;
    logic [bd3_pkg::SUM_W-1:0]   sum_red, sum_green, sum_blue;
    logic [bd3_pkg::COLOR_W-1:0] avg_red, avg_green, avg_blue;
    logic                        use_grid;

    always_comb
    begin
        prev_word = stage_reg.first_row ? '0 : rd_data_reg;
        sum_red   = prev_word[bd3_pkg::SUM_W-1:0] +
                    bd3_pkg::SUM_W'(stage_reg.run_red);
        sum_green = prev_word[2*bd3_pkg::SUM_W-1:bd3_pkg::SUM_W] +
                    bd3_pkg::SUM_W'(stage_reg.run_green);
        sum_blue  = prev_word[3*bd3_pkg::SUM_W-1:2*bd3_pkg::SUM_W] +
                    bd3_pkg::SUM_W'(stage_reg.run_blue);
        avg_red   = bd3_pkg::div9(sum_red);
        avg_green = bd3_pkg::div9(sum_green);
        avg_blue  = bd3_pkg::div9(sum_blue);

        // Pure white over an exact mid-gray grid pixel shows the grid.
        use_grid = grid_enable_reg &&
                   (avg_red   == bd3_pkg::WHITE_LEVEL) &&
                   (avg_green == bd3_pkg::WHITE_LEVEL) &&
                   (avg_blue  == bd3_pkg::WHITE_LEVEL) &&
                   (stage_reg.overlay_red   == bd3_pkg::GRID_GRAY) &&
                   (stage_reg.overlay_green == bd3_pkg::GRID_GRAY) &&
                   (stage_reg.overlay_blue  == bd3_pkg::GRID_GRAY);
    end

    // A column entry is written three or more transfers before it is read
    // again, so the registered read never needs a bypass.
    always_ff @(posedge clk)
    begin
        if (stage_go && stage_reg.wr)
        begin
            col_mem[stage_reg.addr] <= {sum_blue, sum_green, sum_red};
        end
        if (in_fire)
        begin
            rd_data_reg <= col_mem[out_x_cur[bd3_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && stage_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && stage_reg.emit)
        begin
            out_red_reg   <= use_grid ? bd3_pkg::GRID_GRAY : avg_red;
            out_green_reg <= use_grid ? bd3_pkg::GRID_GRAY : avg_green;
            out_blue_reg  <= use_grid ? bd3_pkg::GRID_GRAY : avg_blue;
            row_end_reg   <= stage_reg.row_end;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_red   = out_red_reg;
    assign results.out_green = out_green_reg;
    assign results.out_blue  = out_blue_reg;
    assign results.row_end   = row_end_reg;

    // Checks.
    `BD3_ASSERT_NOW(a_no_overwrite, clk, rst_n,
        out_valid_reg && !results.ready, !(stage_go && stage_reg.emit),
        "stalled result overwritten")

    `BD3_ASSERT_NOW(a_emit_writes, clk, rst_n,
        stage_valid_reg && stage_reg.emit, stage_reg.wr,
        "result from a block that does not update the column store")

    `BD3_ASSERT_NOW(a_line_start, clk, rst_n,
        x_position_reg == '0,
        (col_phase_reg == bd3_pkg::PHASE_FIRST) && (out_x_reg == '0),
        "column counters disagree at line start")

    `BD3_ASSERT_NEXT(a_frame_restart, clk, rst_n,
        in_fire && pixels.frame_start,
        (x_position_reg == '0) || (col_phase_reg == 2'd1),
        "frame start did not restart the position")

endmodule
